/* design/scbpa_pkg.sv */
// Package for the size-class block pool allocator.
// Holds field widths, codes, request/response structs and reset values.
// No dependencies; the controller, datapath and top level import it.
package scbpa_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int MAX_BLOCKS_DEF  = 32;

  // Classes that have configuration registers.
  localparam int NUM_CFG_CLASSES = 4;

  localparam int SIZE_W     = 16;
  localparam int COUNT_W    = 6;
  localparam int CNT_W      = 32;
  localparam int FCLS_W     = 2;
  localparam int FBLK_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 3'd4;

  localparam logic [SIZE_W-1:0]  SIZE_RESET_0  = 16'd128;
  localparam logic [SIZE_W-1:0]  SIZE_RESET_1  = 16'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RESET_2  = 16'd512;
  localparam logic [SIZE_W-1:0]  SIZE_RESET_3  = 16'd1024;
  localparam logic [SIZE_W-1:0]  SIZE_RESET_HI = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET_0 = 6'd10;
  localparam logic [COUNT_W-1:0] COUNT_RESET_1 = 6'd5;
  localparam logic [COUNT_W-1:0] COUNT_RESET_2 = 6'd20;
  localparam logic [COUNT_W-1:0] COUNT_RESET_3 = 6'd8;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_MISS      = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [SIZE_W-1:0] request_size;
    logic [FCLS_W-1:0] free_class;
    logic [FBLK_W-1:0] free_block;
  } alloc_req_t;

  typedef struct packed {
    status_t            status;
    logic [FCLS_W-1:0]  class_index;
    logic [FBLK_W-1:0]  block_index;
    logic [COUNT_W-1:0] free_blocks;
    logic [COUNT_W-1:0] allocated_blocks;
    logic [CNT_W-1:0]   alloc_calls;
    logic [CNT_W-1:0]   free_calls;
    logic [CNT_W-1:0]   miss_count;
  } alloc_rsp_t;

  // Step strobes from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic update;
    logic count;
    logic load;
  } dp_cmd_t;

  function automatic logic [SIZE_W-1:0] size_reset(input int c);
    case (c)
      0:       return SIZE_RESET_0;
      1:       return SIZE_RESET_1;
      2:       return SIZE_RESET_2;
      3:       return SIZE_RESET_3;
      default: return SIZE_RESET_HI;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] count_reset(input int c);
    case (c)
      0:       return COUNT_RESET_0;
      1:       return COUNT_RESET_1;
      2:       return COUNT_RESET_2;
      3:       return COUNT_RESET_3;
      default: return '0;
    endcase
  endfunction

endpackage

/* design/scbpa_stream_if.sv */
// Valid/ready stream interface carrying one request or response payload.
// The payload type is a parameter; the allocator uses the structs of scbpa_pkg.
interface scbpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/scbpa_ctrl.sv */
// Controller of the block pool allocator: one-hot sequencer and output valid.
// Depends on scbpa_pkg for the datapath command struct.
module scbpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output scbpa_pkg::dp_cmd_t cmd
);
  import scbpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_UPDATE = 5'b00100,
    S_COUNT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Wait here while the previous response is still unclaimed.
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/scbpa_datapath.sv */
// Datapath of the block pool allocator: configuration, per-class state,
// class selection, block grant/release, occupancy count and response register.
// Depends on scbpa_pkg; stepped by scbpa_ctrl through dp_cmd_t.
module scbpa_datapath #(
  parameter int NUM_CLASSES = scbpa_pkg::NUM_CLASSES_DEF,
  parameter int MAX_BLOCKS  = scbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scbpa_pkg::dp_cmd_t                   cmd,
  input  scbpa_pkg::alloc_req_t                req_in,
  input  logic                                 cfg_wr_en,
  input  logic [scbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scbpa_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output scbpa_pkg::alloc_rsp_t                rsp_out
);
  import scbpa_pkg::*;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NCHUNK = (MAX_BLOCKS + 7) / 8;
  localparam int PAD_W  = NCHUNK * 8;
  localparam int POP_W  = $clog2(MAX_BLOCKS + 1);

  // Configuration.
  logic [SIZE_W-1:0]  class_size  [NUM_CLASSES];
  logic [COUNT_W-1:0] class_count [NUM_CLASSES];

  // Per-class allocator state.
  logic [MAX_BLOCKS-1:0] alloc_map   [NUM_CLASSES];
  logic [COUNT_W-1:0]    alloc_total [NUM_CLASSES];
  logic [CNT_W-1:0]      alloc_cnt   [NUM_CLASSES];
  logic [CNT_W-1:0]      free_cnt    [NUM_CLASSES];
  logic [CNT_W-1:0]      miss_cnt    [NUM_CLASSES];

  // Per-request working registers.
  alloc_req_t         req_q;
  logic               too_large_q;
  logic               oor_q;
  logic [CLS_W-1:0]   sel_q;
  status_t            status_q;
  logic [FBLK_W-1:0]  blk_q;
  logic [3:0]         chunk_pop [NCHUNK];

  // Selection and grant logic.
  logic                  too_large_c;
  logic [CLS_W-1:0]      sel_c;
  logic                  fc_ok_c;
  logic [COUNT_W-1:0]    pres_c;
  logic [MAX_BLOCKS-1:0] mask_c;
  logic [MAX_BLOCKS-1:0] avail_c;
  logic [BLK_W-1:0]      grant_c;
  logic                  fb_ok_c;
  logic                  fb_busy_c;
  logic [PAD_W-1:0]      busy_pad_c;
  logic [POP_W-1:0]      busy_sum_c;
  logic [COUNT_W:0]      free_diff_c;

  always_comb begin
    too_large_c = req_q.request_size > class_size[NUM_CLASSES-1];
    sel_c       = CLS_W'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (req_q.request_size <= class_size[c]) begin
        sel_c = CLS_W'(c);
      end
    end
    fc_ok_c = 32'(req_q.free_class) < NUM_CLASSES;
  end

  always_comb begin
    // Blocks present in the class are clamped to the pool depth.
    if ({1'b0, class_count[sel_q]} > (COUNT_W + 1)'(MAX_BLOCKS)) begin
      pres_c = COUNT_W'(MAX_BLOCKS);
    end else begin
      pres_c = class_count[sel_q];
    end
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      mask_c[b] = (COUNT_W + 1)'(b) < {1'b0, pres_c};
    end
    avail_c = mask_c & ~alloc_map[sel_q];
    grant_c = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (avail_c[b]) begin
        grant_c = BLK_W'(b);
      end
    end
    fb_ok_c   = 32'(req_q.free_block) < MAX_BLOCKS;
    fb_busy_c = fb_ok_c && alloc_map[sel_q][BLK_W'(req_q.free_block)];
    busy_pad_c = PAD_W'(alloc_map[sel_q] & mask_c);
    busy_sum_c = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      busy_sum_c = busy_sum_c + POP_W'(chunk_pop[i]);
    end
    free_diff_c = {1'b0, pres_c} - (COUNT_W + 1)'(busy_sum_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_size[c]  <= size_reset(c);
        class_count[c] <= count_reset(c);
        alloc_map[c]   <= '0;
        alloc_total[c] <= '0;
        alloc_cnt[c]   <= '0;
        free_cnt[c]    <= '0;
        miss_cnt[c]    <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (c < NUM_CFG_CLASSES && cfg_index[FCLS_W-1:0] == FCLS_W'(c)) begin
            if (cfg_index < CFG_COUNT_BASE) begin
              class_size[c] <= cfg_wr_data;
            end else begin
              class_count[c] <= cfg_wr_data[COUNT_W-1:0];
            end
          end
        end
      end
      if (cmd.update && !too_large_q && !oor_q) begin
        if (req_q.command == CMD_ALLOC) begin
          if (avail_c == '0) begin
            miss_cnt[sel_q] <= miss_cnt[sel_q] + 1'b1;
          end else begin
            alloc_map[sel_q][grant_c] <= 1'b1;
            alloc_total[sel_q]        <= alloc_total[sel_q] + 1'b1;
            alloc_cnt[sel_q]          <= alloc_cnt[sel_q] + 1'b1;
          end
        end else if (fb_busy_c) begin
          alloc_map[sel_q][BLK_W'(req_q.free_block)] <= 1'b0;
          alloc_total[sel_q] <= alloc_total[sel_q] - 1'b1;
          free_cnt[sel_q]    <= free_cnt[sel_q] + 1'b1;
        end
      end
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_in;
    end
    if (cmd.decide) begin
      if (req_q.command == CMD_ALLOC) begin
        too_large_q <= too_large_c;
        oor_q       <= 1'b0;
        // A rejected request reports class 0's counters.
        sel_q       <= too_large_c ? '0 : sel_c;
      end else begin
        too_large_q <= 1'b0;
        oor_q       <= !fc_ok_c;
        sel_q       <= fc_ok_c ? CLS_W'(req_q.free_class) : '0;
      end
    end
    if (cmd.update) begin
      blk_q <= '0;
      if (too_large_q) begin
        status_q <= ST_TOO_LARGE;
      end else if (req_q.command == CMD_ALLOC) begin
        if (avail_c == '0) begin
          status_q <= ST_MISS;
        end else begin
          status_q <= ST_OK;
          blk_q    <= FBLK_W'(grant_c);
        end
      end else if (oor_q || !fb_busy_c) begin
        status_q <= ST_BAD_FREE;
      end else begin
        status_q <= ST_OK;
        blk_q    <= req_q.free_block;
      end
    end
    if (cmd.count) begin
      for (int i = 0; i < NCHUNK; i++) begin
        chunk_pop[i] <= 4'($countones(busy_pad_c[i*8 +: 8]));
      end
    end
    if (cmd.load) begin
      rsp_out.status      <= status_q;
      rsp_out.block_index <= blk_q;
      if (oor_q) begin
        rsp_out.class_index      <= req_q.free_class;
        rsp_out.free_blocks      <= '0;
        rsp_out.allocated_blocks <= '0;
        rsp_out.alloc_calls      <= '0;
        rsp_out.free_calls       <= '0;
        rsp_out.miss_count       <= '0;
      end else begin
        rsp_out.class_index      <= FCLS_W'(sel_q);
        rsp_out.free_blocks      <= free_diff_c[COUNT_W-1:0];
        rsp_out.allocated_blocks <= alloc_total[sel_q];
        rsp_out.alloc_calls      <= alloc_cnt[sel_q];
        rsp_out.free_calls       <= free_cnt[sel_q];
        rsp_out.miss_count       <= miss_cnt[sel_q];
      end
    end
  end

endmodule

/* design/size_class_block_pool_allocator_top.sv */
// Size-class block pool allocator, top level.
// Each accepted request passes through the decide, update, count and load steps of the
// controller before its response is valid; the load step waits while the previous response
// is unclaimed, and the next request is accepted only after the load.
// Reset (rst, synchronous) frees every block, clears all counters and restores the
// class sizes 128/256/512/1024 and block counts 10/5/20/8.
//
// The block serves allocate and free requests over a pool split into size classes.
// Each class keeps one allocated bit per block, an allocated total and three
// wrapping counters (successful allocations, successful frees and misses).
//
// Steps of one request:
//   decide: an allocate picks the lowest class whose size is at least the request,
//           or flags the request as too large; a free checks that its class exists.
//   update: an allocate grants the lowest present free block of that class or counts
//           a miss; a free releases the named block when it is allocated.
//   count:  the allocated present blocks of the class are counted in 8-bit chunks.
//   load:   the chunk counts are summed and the response register is loaded.
// The response register sits between the two channels, so a new request is taken
// while the previous response still waits for the consumer.
//
// Configuration writes land at once and are meant to happen only while the block
// is idle. Lowering a class count leaves blocks beyond it allocated; they can still
// be freed and stay in allocated_blocks, but are not granted again.
module size_class_block_pool_allocator_top #(
  parameter int NUM_CLASSES = scbpa_pkg::NUM_CLASSES_DEF,
  parameter int MAX_BLOCKS  = scbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  scbpa_stream_if.sink                     req,
  scbpa_stream_if.source                   rsp,
  input  logic                             cfg_wr_en,
  input  logic [scbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbpa_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import scbpa_pkg::*;

  // Step strobes from the controller into the datapath.
  dp_cmd_t    cmd;
  logic       in_ready;
  logic       out_valid;
  alloc_req_t req_payload;
  alloc_rsp_t rsp_payload;

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign req_payload = req.payload;
  assign rsp.payload = rsp_payload;

  scbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  scbpa_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_in      (req_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .rsp_out     (rsp_payload)
  );

endmodule
